### rtl/cesd_pkg.sv
package cesd_pkg;

    // decoder mode, plain or one per kind of pending escape
    typedef enum logic [2:0] {
        MODE_PLAIN  = 3'd0,
        MODE_BSLASH = 3'd1,
        MODE_CARET  = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT    = 3'd4,
        MODE_DEC    = 3'd5
    } mode_t;

    localparam int ACC_W = 10;
    localparam int CNT_W = 2;

    // results of one source byte, one or two decoded bytes
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       last;
    } bundle_t;

endpackage

### rtl/c_escape_sequence_decoder_unit.sv
// c string escape decoder: source bytes go in by push/full with end_of_string on the last
// byte of a string, decoded bytes come out by empty/pop with last on the final decoded byte.
// backslash escapes n t b r and backslash are decoded, \x takes up to 2 hex digits, \0 up to
// 2 more octal digits, \1..\9 up to 3 decimal digits in all (value mod 256); with caret_enable
// set, ^c gives c & 0x1f. a non-digit ending a numeric escape is then decoded as plain text,
// so one source byte may give two decoded bytes. a trailing backslash or caret is passed
// through literally and a pending numeric value is flushed at end of string. caret_enable
// resets to 1, written through the cfg channel (cfg_ready is always high); the user must write
// it only while idle, which the block does not enforce. a source byte is accepted each cycle
// that full is low; the classifier works in the same cycle and hands a one- or two-byte bundle
// to a QUEUE_DEPTH-entry bundle queue, from which the output register loads it and hands out
// one decoded word per pop, a two-byte bundle in two pops. full rises only when the queue backs up.
module c_escape_sequence_decoder_unit
    import cesd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    // config write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // source side
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last
);

    logic    caret_enable_reg;
    logic    accept;
    logic    bundle_valid;
    bundle_t bundle;
    bundle_t q_data;
    logic    q_empty, q_pop;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            caret_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            caret_enable_reg <= cfg_data;
        end
    end

    // a source word is taken whenever the queue has room
    assign accept = push && !full;

    // classifier and escape state
    cesd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .caret_enable  (caret_enable_reg),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .bundle_valid  (bundle_valid),
        .bundle        (bundle)
    );

    // bundles between classifier and output stage
    cesd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept && bundle_valid),
        .wdata (bundle),
        .full  (full),
        .rd    (q_pop),
        .rdata (q_data),
        .empty (q_empty)
    );

    // output stage, one decoded word per pop
    cesd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

### rtl/cesd_front.sv
module cesd_front
    import cesd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    caret_enable,
    input  logic    accept,
    input  logic [7:0] in_byte,
    input  logic    end_of_string,
    output logic    bundle_valid,
    output bundle_t bundle
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_0A     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // {valid, value} of c as a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'h00;
            if (c inside {[CH_0:CH_9]}) begin
                t = c - CH_0;
                hex_digit = {1'b1, t[3:0]};
            end else if (c inside {[CH_LA:CH_LF]}) begin
                t = c - CH_LA + 8'd10;
                hex_digit = {1'b1, t[3:0]};
            end else if (c inside {[CH_UA:CH_UF]}) begin
                t = c - CH_UA + 8'd10;
                hex_digit = {1'b1, t[3:0]};
            end else begin
                hex_digit = 5'b0;
            end
        end
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        begin
            case (c)
                CH_N:    esc_map = CH_0A;
                CH_T:    esc_map = CH_TAB;
                CH_B:    esc_map = CH_BS;
                CH_R:    esc_map = CH_CR;
                default: esc_map = c;
            endcase
        end
    endfunction

    mode_t            mode_reg, mode_next, mode_step, plain_tgt;
    logic [ACC_W-1:0] acc_reg, acc_next, acc_step, acc_new, acc_mul;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_step, cnt_plus, limit;
    logic [4:0]       hd;
    logic             is_num, is_digit, take_digit, lim_hit, plain_go;
    logic             e1, e2, e3;
    logic [7:0]       v1, v2, v3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

    // digit recognition for the pending numeric escape
    assign is_num = (mode_reg == MODE_HEX) || (mode_reg == MODE_OCT) || (mode_reg == MODE_DEC);
    assign hd     = hex_digit(in_byte);
    assign limit  = (mode_reg == MODE_HEX) ? 2'd2 : 2'd3;

    always_comb
    begin
        case (mode_reg)
            MODE_HEX:
            begin
                is_digit = hd[4];
                acc_mul  = {acc_reg[5:0], 4'b0};
            end
            MODE_OCT:
            begin
                is_digit = hd[4] && (hd[3:0] < 4'd8);
                acc_mul  = {acc_reg[6:0], 3'b0};
            end
            default:
            begin
                is_digit = hd[4] && (hd[3:0] < 4'd10);
                acc_mul  = {acc_reg[6:0], 3'b0} + {acc_reg[8:0], 1'b0};
            end
        endcase
    end

    assign take_digit = is_num && is_digit && (cnt_reg < limit);
    assign acc_new    = acc_mul + {6'b0, hd[3:0]};
    assign cnt_plus   = cnt_reg + 2'd1;
    assign lim_hit    = (cnt_plus >= limit);
    assign plain_go   = (is_num && !take_digit) ||
                        !(is_num || mode_reg == MODE_BSLASH || mode_reg == MODE_CARET);
    assign plain_tgt  = (in_byte == CH_BSLASH) ? MODE_BSLASH :
                        ((in_byte == CH_CARET) && caret_enable) ? MODE_CARET : MODE_PLAIN;

    // next state
    always_comb
    begin
        mode_step = mode_reg;
        acc_step  = acc_reg;
        cnt_step  = cnt_reg;
        case (mode_reg)
            MODE_BSLASH:
            begin
                acc_step  = '0;
                cnt_step  = '0;
                mode_step = MODE_PLAIN;
                if (in_byte == CH_LX || in_byte == CH_UX)
                begin
                    mode_step = MODE_HEX;
                end
                else if (in_byte == CH_0)
                begin
                    mode_step = MODE_OCT;
                    cnt_step  = 2'd1;
                end
                else if (in_byte inside {[CH_1:CH_9]})
                begin
                    mode_step = MODE_DEC;
                    acc_step  = {2'b0, in_byte - CH_0};
                    cnt_step  = 2'd1;
                end
            end
            MODE_CARET:
            begin
                mode_step = MODE_PLAIN;
            end
            MODE_HEX, MODE_OCT, MODE_DEC:
            begin
                if (take_digit && !lim_hit)
                begin
                    acc_step = acc_new;
                    cnt_step = cnt_plus;
                end
                else
                begin
                    acc_step  = '0;
                    cnt_step  = '0;
                    mode_step = take_digit ? MODE_PLAIN : plain_tgt;
                end
            end
            default:
            begin
                mode_step = plain_tgt;
            end
        endcase
        mode_next = end_of_string ? MODE_PLAIN : mode_step;
        acc_next  = end_of_string ? '0 : acc_step;
        cnt_next  = end_of_string ? '0 : cnt_step;
    end

    // emitted bytes
    always_comb
    begin
        e1 = 1'b0;
        v1 = 8'h00;
        case (mode_reg)
            MODE_BSLASH:
            begin
                e1 = (mode_step == MODE_PLAIN);
                v1 = esc_map(in_byte);
            end
            MODE_CARET:
            begin
                e1 = 1'b1;
                v1 = in_byte & 8'h1F;
            end
            MODE_HEX, MODE_OCT, MODE_DEC:
            begin
                e1 = !take_digit || lim_hit;
                v1 = take_digit ? acc_new[7:0] : acc_reg[7:0];
            end
            default:
            begin
                e1 = 1'b0;
            end
        endcase
        e2 = plain_go && (plain_tgt == MODE_PLAIN);
        v2 = in_byte;
        e3 = end_of_string && (mode_step != MODE_PLAIN);
        case (mode_step)
            MODE_BSLASH: v3 = CH_BSLASH;
            MODE_CARET:  v3 = CH_CARET;
            default:     v3 = acc_step[7:0];
        endcase
        bundle_valid = e1 || e2 || e3;
        bundle.two   = (e1 && e2) || (e1 && e3) || (e2 && e3);
        bundle.b0    = e1 ? v1 : (e2 ? v2 : v3);
        bundle.b1    = (e1 && e2) ? v2 : v3;
        bundle.last  = end_of_string;
    end

endmodule

### rtl/cesd_queue.sv
module cesd_queue
    import cesd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  bundle_t wdata,
    output logic    full,
    input  logic    rd,
    output bundle_t rdata,
    output logic    empty
);

    // the user must keep depth a power of two so the pointers wrap; the queue does not enforce it
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t       mem [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + AW'(1);
            end
            if (rd)
            begin
                rptr_reg <= rptr_reg + AW'(1);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

### rtl/cesd_back.sv
module cesd_back
    import cesd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  bundle_t    q_data,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       last
);

    bundle_t cur_reg;
    logic    valid_reg, second_reg;
    logic    done;

    // current bundle finishes with this pop
    assign done  = pop && valid_reg && (!cur_reg.two || second_reg);
    assign q_pop = (!valid_reg || done) && !q_empty;

    assign empty    = !valid_reg;
    assign out_byte = second_reg ? cur_reg.b1 : cur_reg.b0;
    assign last     = cur_reg.last && (!cur_reg.two || second_reg);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            valid_reg  <= 1'b1;
            second_reg <= 1'b0;
        end
        else if (done)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (pop && valid_reg)
        begin
            second_reg <= 1'b1;
        end
    end

`ifndef SYNTH
    // first byte of a pair taken: second byte follows
    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && valid_reg && cur_reg.two && !second_reg) |=> (valid_reg && second_reg))
        else $error("second byte of pair lost");

    // queue is never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // second byte only ever shown for a pair
    a_second_pair: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (valid_reg && cur_reg.two))
        else $error("second byte shown for single bundle");
`endif

endmodule

### tb/cesd_char_pkg.sv
package cesd_char_pkg;

    // character codes used by the decoder model and the stimulus
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_EIGHT  = 8'h38;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A_UP   = 8'h41;
    localparam logic [7:0] CH_F_UP   = 8'h46;
    localparam logic [7:0] CH_X_UP   = 8'h58;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_B_LO   = 8'h62;
    localparam logic [7:0] CH_F_LO   = 8'h66;
    localparam logic [7:0] CH_N_LO   = 8'h6e;
    localparam logic [7:0] CH_R_LO   = 8'h72;
    localparam logic [7:0] CH_T_LO   = 8'h74;
    localparam logic [7:0] CH_X_LO   = 8'h78;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_MAX    = 8'hff;

    localparam logic [7:0] CTRL_MASK = 8'h1f;

endpackage

### tb/cesd_checker.sv
module cesd_checker
    import cesd_pkg::*;
    import cesd_char_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic       last,
    output int         fail_count,
    output int         words_pending,
    output int         words_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BASE_HEX    = 16;
    localparam int BASE_OCT    = 8;
    localparam int BASE_DEC    = 10;
    localparam int HEX_DIGITS  = 2;
    localparam int NUM_DIGITS  = 3;
    localparam int MAX_REPORTS = 40;

    // predicted decoder state
    mode_t            dec_mode;
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic             caret_en;

    // expected words, {last, out_byte}, oldest first
    logic [8:0] expected_q[$];
    int         fails = 0;
    int         checked = 0;

    assign fail_count    = fails;
    assign words_checked = checked;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fails < MAX_REPORTS)
            $display("%0t ns mismatch on %s: got %02h expected %02h", $time, what, got, want);
        fails++;
    endtask

    task automatic add_word(input logic [7:0] v);
        expected_q.push_back({1'b0, v});
    endtask

    task automatic flush_number();
        add_word(acc[7:0]);
        dec_mode = MODE_PLAIN;
        acc = '0;
        cnt = '0;
    endtask

    task automatic plain_byte(input logic [7:0] c);
        if (c == CH_BSLASH)
            dec_mode = MODE_BSLASH;
        else if (c == CH_CARET && caret_en)
            dec_mode = MODE_CARET;
        else
        begin
            dec_mode = MODE_PLAIN;
            add_word(c);
        end
    endtask

    task automatic decode_source_byte(input logic [7:0] c, input logic eos);
        int         words_before;
        int         base;
        int         limit;
        int         d;
        logic [8:0] tail;
        words_before = expected_q.size();
        case (dec_mode)
            MODE_BSLASH:
            begin
                acc = '0;
                cnt = '0;
                if (c == CH_X_LO || c == CH_X_UP)
                    dec_mode = MODE_HEX;
                else if (c == CH_ZERO)
                begin
                    dec_mode = MODE_OCT;
                    cnt = 2'd1;
                end
                else if (c >= CH_ONE && c <= CH_NINE)
                begin
                    dec_mode = MODE_DEC;
                    acc = ACC_W'(c - CH_ZERO);
                    cnt = 2'd1;
                end
                else
                begin
                    dec_mode = MODE_PLAIN;
                    case (c)
                        CH_N_LO: add_word(CH_LF);
                        CH_T_LO: add_word(CH_TAB);
                        CH_B_LO: add_word(CH_BS);
                        CH_R_LO: add_word(CH_CR);
                        default: add_word(c);
                    endcase
                end
            end
            MODE_CARET:
            begin
                dec_mode = MODE_PLAIN;
                add_word(c & CTRL_MASK);
            end
            MODE_HEX, MODE_OCT, MODE_DEC:
            begin
                base  = (dec_mode == MODE_HEX) ? BASE_HEX :
                        (dec_mode == MODE_OCT) ? BASE_OCT : BASE_DEC;
                limit = (dec_mode == MODE_HEX) ? HEX_DIGITS : NUM_DIGITS;
                d = -1;
                if (c >= CH_ZERO && c <= CH_NINE)
                    d = int'(c) - int'(CH_ZERO);
                else if (base == BASE_HEX && c >= CH_A_LO && c <= CH_F_LO)
                    d = int'(c) - int'(CH_A_LO) + 10;
                else if (base == BASE_HEX && c >= CH_A_UP && c <= CH_F_UP)
                    d = int'(c) - int'(CH_A_UP) + 10;
                if (d >= base)
                    d = -1;
                if (d >= 0 && cnt < limit)
                begin
                    acc = ACC_W'(acc * base + d);
                    cnt = cnt + 2'd1;
                    if (cnt >= limit)
                        flush_number();
                end
                else
                begin
                    // non-digit closes the number, then decodes as plain text
                    flush_number();
                    plain_byte(c);
                end
            end
            default: plain_byte(c);
        endcase
        if (eos)
        begin
            case (dec_mode)
                MODE_BSLASH:                 add_word(CH_BSLASH);
                MODE_CARET:                  add_word(CH_CARET);
                MODE_HEX, MODE_OCT, MODE_DEC: add_word(acc[7:0]);
                default: ;
            endcase
            dec_mode = MODE_PLAIN;
            acc = '0;
            cnt = '0;
            if (expected_q.size() > words_before)
            begin
                tail = expected_q.pop_back();
                tail[8] = 1'b1;
                expected_q.push_back(tail);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [8:0] want;
        if (!rst_n)
        begin
            dec_mode = MODE_PLAIN;
            acc = '0;
            cnt = '0;
            caret_en = 1'b1;
            expected_q.delete();
            words_pending <= 0;
        end
        else
        begin
            if (!empty && pop)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected word", out_byte, 8'h00);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_byte !== want[7:0])
                        report_mismatch("out_byte", out_byte, want[7:0]);
                    if (last !== want[8])
                        report_mismatch("last", {7'd0, last}, {7'd0, want[8]});
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
                caret_en = cfg_data;
            if (push && !full)
                decode_source_byte(in_byte, end_of_string);
            words_pending <= expected_q.size();
        end
    end

endmodule

### tb/tb_c_escape_sequence_decoder_unit.sv
module tb_c_escape_sequence_decoder_unit;

    import cesd_char_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1550;
    localparam int PHASES       = 4;
    localparam int CYCLE_LIMIT  = 500000;

    // receiver stall styles
    localparam int POP_ALWAYS  = 0;
    localparam int POP_COIN    = 1;
    localparam int POP_SPARSE  = 2;
    localparam int POP_PATTERN = 3;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_string = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] out_byte;
    logic       last;

    int fail_count;
    int words_pending;
    int words_checked;

    // source side bookkeeping
    logic [7:0] src_q[$];
    int         burst_left = 0;
    int         items_sent = 0;
    int         strings_sent = 0;
    int         cfg_writes = 0;
    int         cycles = 0;

    // receiver stall pattern
    int         stall_style = POP_ALWAYS;
    int         stall_left = 0;
    logic [7:0] stall_ring = 8'b1011_0010;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    c_escape_sequence_decoder_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last          (last)
    );

    cesd_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last          (last),
        .fail_count    (fail_count),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    // watchdog, covers a hung handshake or words that never show up
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: style is redrawn at random, one pop update per edge
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(POP_ALWAYS, POP_PATTERN);
            stall_left  <= $urandom_range(16, 160);
        end
        else
            stall_left <= stall_left - 1;
        stall_ring <= {stall_ring[0], stall_ring[7:1]};
        case (stall_style)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(0, 1));
            POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:    pop <= stall_ring[0];
        endcase
    end

    // one source word, held until the decoder takes it; bursts with random gaps
    task automatic send_word(input logic [7:0] c, input logic eos);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
        end
        burst_left--;
        push          <= 1'b1;
        in_byte       <= c;
        end_of_string <= eos;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
        strings_sent++;
    endtask

    task automatic send_queued();
        int i;
        for (i = 0; i < src_q.size(); i++)
            send_word(src_q[i], i == src_q.size() - 1);
        strings_sent++;
    endtask

    // sender holds off until every predicted word is out, then a short settle
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_caret(input logic v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [7:0] hex_char(input int d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(d - 10);
    endfunction

    // one random fragment of a string: mostly well-formed escapes, some noise
    task automatic add_piece();
        int         kind;
        int         n;
        int         i;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            // printable text, no escape starters
            c = 8'($urandom_range(CH_SPACE, CH_TILDE));
            if (c == CH_BSLASH || c == CH_CARET)
                c = CH_A_LO;
            src_q.push_back(c);
        end
        else if (kind < 45)
        begin
            src_q.push_back(CH_BSLASH);
            case ($urandom_range(0, 5))
                0:       src_q.push_back(CH_N_LO);
                1:       src_q.push_back(CH_T_LO);
                2:       src_q.push_back(CH_B_LO);
                3:       src_q.push_back(CH_R_LO);
                4:       src_q.push_back(CH_BSLASH);
                default: src_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        else if (kind < 55)
        begin
            // hex, zero to two digits, either case of x
            src_q.push_back(CH_BSLASH);
            src_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
                src_q.push_back(hex_char($urandom_range(0, 15)));
        end
        else if (kind < 63)
        begin
            // octal, sometimes cut short by 8 or 9
            src_q.push_back(CH_BSLASH);
            src_q.push_back(CH_ZERO);
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
                src_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0)
                src_q.push_back($urandom_range(0, 1) ? CH_EIGHT : CH_NINE);
        end
        else if (kind < 73)
        begin
            // decimal, up to three digits in all, may overflow a byte
            src_q.push_back(CH_BSLASH);
            src_q.push_back(CH_ONE + 8'($urandom_range(0, 8)));
            n = $urandom_range(0, 2);
            for (i = 0; i < n; i++)
                src_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (kind < 83)
        begin
            src_q.push_back(CH_CARET);
            src_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 96)
            src_q.push_back(8'($urandom_range(0, 255)));
        else
            src_q.push_back(CH_BSLASH);
    endtask

    initial
    begin : stimulus
        int p;
        int i;
        int n;
        int random_start;
        // reset once, held at the start and then released
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: named escapes at reset caret setting
        send_text("\\n\\t\\b\\r");
        // escaped backslash, then hex with no digits ended by a letter
        send_text("\\\\\\xG");
        // decimal overflow wraps
        send_text("\\999");
        // octal value flushed at end of string
        send_text("\\07");
        // trailing backslash and trailing caret come out literally
        send_text("\\");
        send_text("^");
        // extremes of the byte range
        send_word(CH_NUL, 1'b1);
        send_word(CH_MAX, 1'b1);
        strings_sent += 2;
        // caret seen, then caret syntax switched off before its operand
        send_word(CH_CARET, 1'b0);
        set_caret(1'b0);
        send_word(CH_A_UP, 1'b1);
        strings_sent++;

        // random phases, caret syntax alternating; each starts from a full drain
        random_start = items_sent;
        for (p = 0; p < PHASES; p++)
        begin
            set_caret(p % 2 == 0);
            while (items_sent - random_start < RANDOM_WORDS * (p + 1) / PHASES)
            begin
                src_q.delete();
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    add_piece();
                send_queued();
            end
        end

        // let the last words out, then idle for stragglers
        wait_drained();
        repeat (8) @(posedge clk);

        $display("ran %0d source words in %0d strings, %0d decoded words compared",
                 items_sent, strings_sent, words_checked);
        $display("caret syntax rewritten %0d times, gaps and stalls on both sides",
                 cfg_writes);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
